/* hdl/bucket_key_hash_top_defines.svh */
// Assertion macros for the bucket key hash engine.
`ifndef BUCKET_KEY_HASH_TOP_DEFINES_SVH
`define BUCKET_KEY_HASH_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BKH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BKH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bkh_pkg.sv */
// Package with shared types and constants for the bucket key hash.
`timescale 1ns / 1ps

package bkh_pkg;

	// Key kind selector codes.
	localparam logic [1:0] KIND_INT  = 2'd0;
	localparam logic [1:0] KIND_DEC  = 2'd1;
	localparam logic [1:0] KIND_UUID = 2'd2;

	// Default depth of the queue between the front and back parts.
	localparam int BKH_QUEUE_DEPTH = 2;

	// Murmur3 x86 32-bit constants.
	localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2   = 32'h1b873593;
	localparam logic [31:0] MM_M5   = 32'd5;
	localparam logic [31:0] MM_ADD  = 32'he6546b64;
	localparam logic [31:0] MM_FMX1 = 32'h85ebca6b;
	localparam logic [31:0] MM_FMX2 = 32'hc2b2ae35;

	// A classified key: byte string with byte 0 in the top bits, its length
	// in bytes (1 to 16), and a flag for a selector with no meaning.
	typedef struct packed {
		logic [127:0] data;
		logic [4:0]   len;
		logic         zero;
	} bkh_entry_t;

endpackage

/* hdl/bkh_front.sv */
// Front part: accepts keys, builds the byte string and its length.
`timescale 1ns / 1ps

module bkh_front import bkh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  func,
	input  logic [63:0] value_high,
	input  logic [63:0] value_low,
	input  logic        key_valid,
	output logic        key_stall,
	output logic        entry_valid_s1,
	output bkh_entry_t  entry_s1,
	input  logic        entry_stall
);

	logic [127:0] be_bytes;
	logic [14:0]  sign_byte;
	logic [3:0]   skip;
	bkh_entry_t   entry;

	assign be_bytes = {value_high, value_low};

	// A byte is redundant when it only repeats the sign of the byte after it.
	always_comb begin
		logic [7:0] cur;
		logic [7:0] nxt;
		for (int i = 0; i < 15; i++) begin
			cur = be_bytes[127 - 8 * i -: 8];
			nxt = be_bytes[119 - 8 * i -: 8];
			sign_byte[i] = ((cur == 8'h00) && !nxt[7]) || ((cur == 8'hFF) && nxt[7]);
		end
	end

	// Count of leading redundant bytes.
	always_comb begin
		logic run;
		run  = 1'b1;
		skip = '0;
		for (int i = 0; i < 15; i++) begin
			if (run && sign_byte[i]) begin
				skip = skip + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
	end

	always_comb begin
		entry = '0;
		unique case (func)
			KIND_INT: begin
				for (int i = 0; i < 8; i++) begin
					entry.data[127 - 8 * i -: 8] = value_low[8 * i +: 8];
				end
				entry.len = 5'd8;
			end
			KIND_DEC: begin
				entry.data = be_bytes << {skip, 3'b000};
				entry.len  = 5'd16 - {1'b0, skip};
			end
			KIND_UUID: begin
				entry.data = be_bytes;
				entry.len  = 5'd16;
			end
			default: begin
				entry.zero = 1'b1;
				entry.len  = 5'd16;
			end
		endcase
	end

	assign key_stall = entry_valid_s1 && entry_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else if (!key_stall) begin
			entry_valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!key_stall && key_valid) begin
			entry_s1 <= entry;
		end
	end

endmodule

/* hdl/bkh_queue.sv */
// Short queue between the front and back parts.
`timescale 1ns / 1ps

module bkh_queue import bkh_pkg::*; #(
	parameter int DEPTH = BKH_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  bkh_entry_t push_entry,
	output logic       push_stall,
	output logic       pop_valid,
	output bkh_entry_t pop_entry,
	input  logic       pop_stall
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bkh_entry_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_stall = (count_q == CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

/* hdl/bkh_back.sv */
// Back part: iterative Murmur3 engine around one shared 32x32 multiplier.
`timescale 1ns / 1ps
`include "bucket_key_hash_top_defines.svh"

module bkh_back import bkh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	input  bkh_entry_t  pop_entry,
	output logic        pop_stall,
	output logic [31:0] hash,
	output logic        hash_valid,
	input  logic        hash_stall
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_C1   = 3'd1;
	localparam logic [2:0] S_C2   = 3'd2;
	localparam logic [2:0] S_H5   = 3'd3;
	localparam logic [2:0] S_F0   = 3'd4;
	localparam logic [2:0] S_F1   = 3'd5;
	localparam logic [2:0] S_F2   = 3'd6;

	logic [2:0]   state_q;
	logic [127:0] data_q;
	logic [4:0]   rem_q;
	logic [4:0]   len_q;
	logic [31:0]  h_q;
	logic [31:0]  k_q;
	logic [31:0]  hash_q;
	logic         hash_valid_q;

	logic [31:0]  word;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_full;
	logic [31:0]  prod;
	logic [31:0]  fin0;
	logic [31:0]  fin1;
	logic         out_free;
	logic         hash_load;

	// Next block or tail word, little-endian from the front of the string.
	always_comb begin
		priority if (rem_q >= 5'd4) begin
			word = {data_q[103:96], data_q[111:104], data_q[119:112], data_q[127:120]};
		end else if (rem_q == 5'd3) begin
			word = {8'h00, data_q[111:104], data_q[119:112], data_q[127:120]};
		end else if (rem_q == 5'd2) begin
			word = {16'h0000, data_q[119:112], data_q[127:120]};
		end else begin
			word = {24'h000000, data_q[127:120]};
		end
	end

	assign fin0 = h_q ^ {27'd0, len_q};
	assign fin1 = h_q ^ (h_q >> 13);

	always_comb begin
		unique case (state_q)
			S_C1: begin
				mul_a = word;
				mul_b = MM_C1;
			end
			S_C2: begin
				mul_a = {k_q[16:0], k_q[31:17]};
				mul_b = MM_C2;
			end
			S_H5: begin
				mul_a = {h_q[18:0], h_q[31:19]};
				mul_b = MM_M5;
			end
			S_F0: begin
				mul_a = fin0 ^ (fin0 >> 16);
				mul_b = MM_FMX1;
			end
			S_F1: begin
				mul_a = fin1;
				mul_b = MM_FMX2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign prod     = mul_full[31:0];

	assign pop_stall  = (state_q != S_IDLE);
	assign out_free   = !hash_valid_q || !hash_stall;
	assign hash_load  = (state_q == S_F2) && out_free;
	assign hash       = hash_q;
	assign hash_valid = hash_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hash_valid_q <= 1'b0;
		end else begin
			if (hash_load) begin
				hash_valid_q <= 1'b1;
			end else if (!hash_stall) begin
				hash_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= pop_entry.zero ? S_F2 : S_C1;
					end
				end
				S_C1: state_q <= S_C2;
				S_C2: state_q <= (rem_q >= 5'd4) ? S_H5 : S_F0;
				S_H5: state_q <= (rem_q == 5'd4) ? S_F0 : S_C1;
				S_F0: state_q <= S_F1;
				S_F1: state_q <= S_F2;
				S_F2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				data_q <= pop_entry.data;
				rem_q  <= pop_entry.len;
				len_q  <= pop_entry.len;
				h_q    <= '0;
			end
			S_C1: k_q <= prod;
			S_C2: h_q <= h_q ^ prod;
			S_H5: begin
				h_q    <= prod + MM_ADD;
				data_q <= data_q << 32;
				rem_q  <= rem_q - 5'd4;
			end
			S_F0: h_q <= prod;
			S_F1: h_q <= prod;
			S_F2: begin
				if (out_free) begin
					hash_q <= h_q ^ (h_q >> 16);
				end
			end
			default: begin
			end
		endcase
	end

	`BKH_ASSERT_IMP(a_block_has_bytes, state_q == S_C1, rem_q != 5'd0,
		"block step started with no bytes left")
	`BKH_ASSERT_NXT(a_load_path, (state_q == S_IDLE) && pop_valid,
		(state_q == S_C1) || (state_q == S_F2), "load did not start a key")
	`BKH_ASSERT_NXT(a_unused_kind_zero, (state_q == S_IDLE) && pop_valid && pop_entry.zero,
		h_q == 32'd0, "unused kind did not clear the hash")
	`BKH_ASSERT_IMP(a_rem_bound, (state_q != S_IDLE) && (state_q != S_F2),
		(rem_q <= len_q) && (len_q <= 5'd16), "byte count out of range")

endmodule

/* hdl/bucket_key_hash_top.sv */
// Top level of the bucket key hash: front classifier, queue and hash engine.
// A key passes the front register and the queue. Per four-byte block the engine
// multiplies by c1, by c2 and by five with the add; a partial tail gets c1 and
// c2 only; the final mix multiplies by both fmix constants and loads the output
// register; an unused selector skips to that load. With one shared multiplier,
// the engine takes no new key until the last is done, and waits on hash stall.
// Asynchronous active-low reset empties the front register, queue and engine.
`timescale 1ns / 1ps

module bucket_key_hash_top import bkh_pkg::*; #(
	parameter int QUEUE_DEPTH = BKH_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  func,
	input  logic [63:0] value_high,
	input  logic [63:0] value_low,
	input  logic        key_valid,
	output logic        key_stall,
	output logic [31:0] hash,
	output logic        hash_valid,
	input  logic        hash_stall
);

	// The front part turns a key into its byte string: little-endian for an
	// integer, big-endian for a uuid, and big-endian with the redundant sign
	// bytes removed for a decimal. It holds one classified key in a register.
	bkh_entry_t front_entry;
	logic       front_valid;
	logic       front_stall;

	// The queue lets the front take the next transfer while the engine is busy.
	bkh_entry_t queue_entry;
	logic       queue_valid;
	logic       queue_stall;

	bkh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.func           (func),
		.value_high     (value_high),
		.value_low      (value_low),
		.key_valid      (key_valid),
		.key_stall      (key_stall),
		.entry_valid_s1 (front_valid),
		.entry_s1       (front_entry),
		.entry_stall    (front_stall)
	);

	bkh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_entry (front_entry),
		.push_stall (front_stall),
		.pop_valid  (queue_valid),
		.pop_entry  (queue_entry),
		.pop_stall  (queue_stall)
	);

	// The engine walks the string four bytes at a time, then the tail and the
	// final mix, and parks the result in an output register; while that register
	// holds a stalled result, the engine waits in its last step.
	bkh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (queue_valid),
		.pop_entry  (queue_entry),
		.pop_stall  (queue_stall),
		.hash       (hash),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall)
	);

endmodule

/* tb/bucket_key_hash_top_tb.sv */
// Self-checking testbench for the bucket key hash top level.
`timescale 1ns / 1ps

module bucket_key_hash_top_tb;
	import bkh_pkg::*;

	// The selector code that has no meaning; the block still answers, with zero.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Random keys per flow-control phase, and the number of phases.
	localparam int KEYS_PER_PHASE = 225;
	localparam int NUM_PHASES = 4;

	// Scoreboard: predicts the hash of every accepted key and checks the hashes
	// that come out, in order. The block carries nothing from one key to the next, so
	// a key's hash depends on nothing but the key itself.
	class bucket_hash_board;
		logic [31:0] pending_hashes[$];
		int          mismatch_count;
		int          hashes_checked;
		int          keys_by_kind[4];

		// Scrambles one 32-bit block: multiply, rotate left by 15, multiply.
		function logic [31:0] scramble_block(input logic [31:0] blk);
			logic [31:0] k;
			k = blk * MM_C1;
			k = {k[16:0], k[31:17]};
			return k * MM_C2;
		endfunction

		// Murmur3 x86 32-bit, seed zero, over msg[first .. first + nbytes - 1].
		function logic [31:0] murmur3_32(input logic [7:0] msg[16], input int first,
				input int nbytes);
			logic [31:0] h;
			logic [31:0] k;
			int          nblk;
			int          tail;
			int          rem;
			h = 32'd0;
			k = 32'd0;
			nblk = nbytes / 4;
			rem = nbytes % 4;
			for (int i = 0; i < nblk; i++) begin
				// Blocks are read little-endian.
				h ^= scramble_block({msg[first + 4*i + 3], msg[first + 4*i + 2],
					msg[first + 4*i + 1], msg[first + 4*i]});
				h = {h[18:0], h[31:19]};
				h = h * MM_M5 + MM_ADD;
			end
			tail = first + 4 * nblk;
			if (rem >= 3)
				k ^= {8'h00, msg[tail + 2], 16'h0000};
			if (rem >= 2)
				k ^= {16'h0000, msg[tail + 1], 8'h00};
			if (rem >= 1) begin
				k ^= {24'h000000, msg[tail]};
				h ^= scramble_block(k);
			end
			h ^= 32'(nbytes);
			h ^= h >> 16;
			h = h * MM_FMX1;
			h ^= h >> 13;
			h = h * MM_FMX2;
			h ^= h >> 16;
			return h;
		endfunction

		// Records a key that the block accepted and queues its expected hash.
		function void note_key(input logic [1:0] kind, input logic [63:0] hi,
				input logic [63:0] lo);
			logic [7:0]   msg[16];
			logic [127:0] wide;
			int           first;
			int           nbytes;
			wide = {hi, lo};
			first = 0;
			nbytes = 16;
			for (int i = 0; i < 16; i++)
				msg[i] = wide[127 - 8*i -: 8];
			keys_by_kind[kind]++;
			case (kind)
				KIND_INT: begin
					// The integer goes out as eight little-endian bytes; hi plays no part.
					for (int i = 0; i < 8; i++)
						msg[i] = lo[8*i +: 8];
					nbytes = 8;
				end
				KIND_DEC: begin
					// Drop leading bytes that only repeat the sign of the next byte.
					while (first < 15 &&
							((msg[first] == 8'h00 && !msg[first + 1][7]) ||
							(msg[first] == 8'hFF && msg[first + 1][7])))
						first++;
					nbytes = 16 - first;
				end
				default: ;
			endcase
			if (kind == KIND_UNUSED)
				pending_hashes.push_back(32'd0);
			else
				pending_hashes.push_back(murmur3_32(msg, first, nbytes));
		endfunction

		// Compares a hash that left the block with the oldest prediction.
		function void check_hash(input logic [31:0] got);
			logic [31:0] want;
			hashes_checked++;
			if (pending_hashes.size() == 0) begin
				$error("hash: none expected, actual %08h", got);
				mismatch_count++;
				return;
			end
			want = pending_hashes.pop_front();
			if (got !== want) begin
				$error("hash: expected %08h, actual %08h", want, got);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic [1:0]  func;
	logic [63:0] value_high;
	logic [63:0] value_low;
	logic        key_valid;
	logic        key_stall;
	logic [31:0] hash;
	logic        hash_valid;
	logic        hash_stall;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int idle_pct;
	int stall_pct;

	bucket_hash_board board;

	bucket_key_hash_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.value_high (value_high),
		.value_low  (value_low),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.hash       (hash),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on run time. A correct run takes well under a tenth of this,
	// even with both sides idling most of the time.
	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	// The receiver decides afresh on every cycle whether to stall. Stall does not
	// look at hash_valid, so stalls land on idle cycles and on results alike.
	always @(posedge clk) begin
		hash_stall <= ($urandom_range(99) < stall_pct);
	end

	// Both channels are observed here. Signals are read in the active region of
	// the edge, before any nonblocking update, so they hold the values that the
	// block itself sees at this edge. A key transfer and a hash transfer happen
	// exactly when valid is high and stall is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (key_valid && !key_stall)
				board.note_key(func, value_high, value_low);
			if (hash_valid && !hash_stall)
				board.check_hash(hash);
		end
	end

	// Presents one key and returns at the edge where it transfers. Before the key,
	// the sender may idle for a while; while idle it puts junk on the payload so
	// that the block is seen to ignore it. Valid is raised at most once per edge,
	// and the payload holds still for as long as the block stalls.
	task automatic send_key(input logic [1:0] kind, input logic [63:0] hi,
			input logic [63:0] lo);
		while ($urandom_range(99) < idle_pct) begin
			key_valid <= 1'b0;
			func <= 2'($urandom);
			value_high <= {$urandom, $urandom};
			value_low <= {$urandom, $urandom};
			@(posedge clk);
		end
		key_valid <= 1'b1;
		func <= kind;
		value_high <= hi;
		value_low <= lo;
		do
			@(posedge clk);
		while (key_stall);
	endtask

	// A decimal of a random significant length from 1 to 16 bytes: random bits
	// sign-extended from the top of the chosen length. This spreads the trimmed
	// lengths evenly, so every tail length of the hash is reached often.
	function automatic logic [127:0] random_decimal();
		logic [127:0] raw;
		int           nbytes;
		raw = {$urandom, $urandom, $urandom, $urandom};
		nbytes = $urandom_range(16, 1);
		return $signed(raw) >>> (128 - 8 * nbytes);
	endfunction

	// An integer key: half fully random, half small values of either sign.
	function automatic logic [63:0] random_integer();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if ($urandom_range(1))
			return raw;
		return $signed(raw) >>> $urandom_range(63, 0);
	endfunction

	// One random key of any kind, the unused selector among them now and then.
	task automatic send_random_key();
		int          pick;
		logic [127:0] dec;
		pick = $urandom_range(99);
		if (pick < 30) begin
			send_key(KIND_INT, {$urandom, $urandom}, random_integer());
		end else if (pick < 70) begin
			dec = random_decimal();
			send_key(KIND_DEC, dec[127:64], dec[63:0]);
		end else if (pick < 95) begin
			send_key(KIND_UUID, {$urandom, $urandom}, {$urandom, $urandom});
		end else begin
			send_key(KIND_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	initial begin
		board = new();
		idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		key_valid <= 1'b0;
		func <= KIND_INT;
		value_high <= 64'd0;
		value_low <= 64'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed keys, with no idling on either side.
		// Integers: zero, all ones, both sign extremes, and a nonzero upper
		// half, which must have no effect on the hash.
		send_key(KIND_INT, 64'd0, 64'd0);
		send_key(KIND_INT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_key(KIND_INT, 64'd0, 64'h8000_0000_0000_0000);
		send_key(KIND_INT, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_key(KIND_INT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0022);
		send_key(KIND_INT, 64'hA5A5_5A5A_0123_4567, 64'h0000_0000_0000_0022);
		// Decimals: zero and minus one each trim to a single byte; 127 and -128
		// stay at one byte; 128 and -129 need a second byte to keep the sign.
		send_key(KIND_DEC, 64'd0, 64'd0);
		send_key(KIND_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_key(KIND_DEC, 64'd0, 64'h7F);
		send_key(KIND_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF80);
		send_key(KIND_DEC, 64'd0, 64'h80);
		send_key(KIND_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF7F);
		// Three, four and five significant bytes: a tail, a whole block, and a
		// block plus a tail.
		send_key(KIND_DEC, 64'd0, 64'h12_3456);
		send_key(KIND_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8123_4567);
		send_key(KIND_DEC, 64'd0, 64'h00_8000_0000);
		// The largest and smallest decimals keep all sixteen bytes.
		send_key(KIND_DEC, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_key(KIND_DEC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
		// UUIDs: all zero, all ones, and a typical one.
		send_key(KIND_UUID, 64'd0, 64'd0);
		send_key(KIND_UUID, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_key(KIND_UUID, 64'hF79C_3E09_677C_4BBD, 64'hA479_3C67_E8A3_C4AC);
		// The unused selector, with payload bits both set and clear.
		send_key(KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_key(KIND_UNUSED, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);

		// Random keys in four flow-control phases: free flow, a mostly idle
		// sender, a mostly stalling receiver, and light idling on both sides.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			for (int n = 0; n < KEYS_PER_PHASE; n++)
				send_random_key();
		end
		key_valid <= 1'b0;

		// The last transfer is noted at the edge where send_key returned, so one
		// more edge makes sure it is on the scoreboard. Then drain, and watch a
		// little longer for any hash that should not come.
		@(posedge clk);
		while (board.pending_hashes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d keys: %0d integer, %0d decimal, %0d uuid, %0d unused kind.",
			board.keys_by_kind[0] + board.keys_by_kind[1] + board.keys_by_kind[2] +
			board.keys_by_kind[3], board.keys_by_kind[KIND_INT],
			board.keys_by_kind[KIND_DEC], board.keys_by_kind[KIND_UUID],
			board.keys_by_kind[KIND_UNUSED]);
		$display("Checked %0d hashes across four idle and stall mixes, %0d mismatches.",
			board.hashes_checked, board.mismatch_count);
		if (board.mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* bucket_key_hash_top.f */
+incdir+hdl
hdl/bkh_pkg.sv
hdl/bkh_front.sv
hdl/bkh_queue.sv
hdl/bkh_back.sv
hdl/bucket_key_hash_top.sv
tb/bucket_key_hash_top_tb.sv
